// ===== src/dmc_pkg.sv =====
// Shared types and constants for the depth-first maze carver.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dmc_pkg;

    // Default grid bound; the top level's MAX_DIM parameter starts here.
    localparam int MAX_DIM_DEF = 32;

    // Fixed field widths of the request, the result and the registers.
    localparam int CFG_W   = 6;
    localparam int RND_W   = 16;
    localparam int FIELD_W = 5;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    // Reset value of both size registers.
    localparam logic [CFG_W-1:0] DIM_RESET = 6'd32;

    // Register indexes, taken from the word address bit of paddr.
    localparam logic REG_HEIGHT = 1'b0;
    localparam logic REG_WIDTH  = 1'b1;

    // Reciprocal of three for a 16-bit dividend: q = (x * RECIP3) >> RECIP3_SHIFT.
    localparam logic [16:0] RECIP3       = 17'd43691;
    localparam int          RECIP3_SHIFT = 17;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        EV_ENTRANCE  = 2'd0,
        EV_CARVE     = 2'd1,
        EV_BACKTRACK = 2'd2,
        EV_DONE      = 2'd3
    } event_t;

    typedef enum logic [1:0]
    {
        DIR_UP    = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_CLEAR,
        S_ENTER,
        S_READ,
        S_DECIDE,
        S_POP
    } state_t;

    // Size registers as seen by the sequencer.
    typedef struct packed
    {
        logic [CFG_W-1:0] height;
        logic [CFG_W-1:0] width;
    } cfg_t;

    // One result with its strobe.
    typedef struct packed
    {
        logic               strobe;
        event_t             kind;
        logic [FIELD_W-1:0] from_row;
        logic [FIELD_W-1:0] from_col;
        logic [FIELD_W-1:0] to_row;
        logic [FIELD_W-1:0] to_col;
        dir_t               dir;
        logic               exit_opened;
    } result_t;

endpackage

`default_nettype wire

// ===== src/dmc_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Takes its default depth from dmc_pkg; instantiated for the visited map and the path stack.
`default_nettype none

module dmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = dmc_pkg::MAX_DIM_DEF * dmc_pkg::MAX_DIM_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and read-first registered read at the same address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/dmc_rem.sv =====
// Iterative remainder unit: 16-bit dividend modulo a narrow divisor,
// one dividend bit per cycle. Depends on dmc_pkg for the dividend width.
`default_nettype none

module dmc_rem #(
    parameter int DIVW = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [dmc_pkg::RND_W-1:0]  dividend,
    input  wire logic [DIVW-1:0]            divisor,
    output logic                            done,
    output logic      [DIVW-1:0]            remainder
);

    localparam int CNT_W = $clog2(dmc_pkg::RND_W + 1);

    logic [DIVW-1:0]           rem_reg,   rem_next;
    logic [dmc_pkg::RND_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]          cnt_reg,   cnt_next;
    logic                      run_reg,   run_next;
    logic [DIVW:0]             trial;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            run_reg <= run_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
    end

    // Restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        rem_next   = rem_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        trial      = {rem_reg, shift_reg[dmc_pkg::RND_W-1]};
        if (trial >= {1'b0, divisor})
        begin
            trial = trial - {1'b0, divisor};
        end
        if (start)
        begin
            rem_next   = '0;
            shift_next = dividend;
            cnt_next   = CNT_W'(dmc_pkg::RND_W);
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next   = DIVW'(trial);
            shift_next = {shift_reg[dmc_pkg::RND_W-2:0], 1'b0};
            cnt_next   = cnt_reg - CNT_W'(1);
            run_next   = (cnt_reg != CNT_W'(1));
        end
    end

    assign done      = !run_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== src/dmc_seq.sv =====
// Sequencer of the maze carver: visited map and path stack memories,
// the start-row remainder unit and the search state machine.
// Depends on dmc_pkg, dmc_ram and dmc_rem.
`default_nettype none

module dmc_seq #(
    parameter int MAX_DIM = dmc_pkg::MAX_DIM_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          opcode,
    input  wire logic [dmc_pkg::RND_W-1:0]     random_word,
    input  wire dmc_pkg::cfg_t                 cfg,
    output logic                               busy,
    output dmc_pkg::result_t                   result
);

    localparam int RB        = $clog2(MAX_DIM);
    localparam int CB        = 2 * RB;
    localparam int MEM_DEPTH = 1 << CB;
    localparam int CELLS     = MAX_DIM * MAX_DIM;
    localparam int SCW       = $clog2(CELLS + 1);
    localparam int DW        = $clog2(MAX_DIM + 1);
    localparam int XW        = (RB > dmc_pkg::FIELD_W) ? RB : dmc_pkg::FIELD_W;

    dmc_pkg::state_t           state_reg,   state_next;
    logic [RB-1:0]             cur_row_reg, cur_row_next;
    logic [RB-1:0]             cur_col_reg, cur_col_next;
    logic [SCW-1:0]            count_reg,   count_next;
    logic [dmc_pkg::RND_W-1:0] rnd_reg,     rnd_next;
    logic [1:0]                mod3_reg,    mod3_next;
    dmc_pkg::dir_t             nbr_reg,     nbr_next;
    logic [2:0]                seen_reg,    seen_next;
    logic [CB-1:0]             clr_reg,     clr_next;
    dmc_pkg::result_t          result_reg,  result_next;

    logic [DW-1:0]  h_eff;
    logic [DW-1:0]  w_eff;
    logic [3:0]     inbound;
    logic [3:0]     visited;
    logic [3:0]     free_nbr;
    logic [2:0]     found;
    logic [2:0]     seen_cnt;
    logic [1:0]     pick;
    dmc_pkg::dir_t  chosen;
    logic [CB-1:0]  chosen_cell;
    logic           push_ok;
    logic [32:0]    recip_prod;
    logic [15:0]    recip_q;
    logic [17:0]    mod3_diff;

    logic           vis_we;
    logic [CB-1:0]  vis_addr;
    logic           vis_wdata;
    logic           vis_rdata;
    logic           stk_we;
    logic [CB-1:0]  stk_addr;
    logic [CB-1:0]  stk_wdata;
    logic [CB-1:0]  stk_rdata;
    logic           rem_start;
    logic           rem_done;
    logic [DW-1:0]  rem_value;

    // Size register clamped to the range 2..MAX_DIM.
    function automatic logic [DW-1:0] clamp_dim(input logic [dmc_pkg::CFG_W-1:0] v);
        if (v < dmc_pkg::CFG_W'(2))
        begin
            return DW'(2);
        end
        else if (int'(v) > MAX_DIM)
        begin
            return DW'(MAX_DIM);
        end
        return DW'(v);
    endfunction

    // Cell address of the neighbor in direction d.
    function automatic logic [CB-1:0] step_cell(input logic [RB-1:0] r,
                                                input logic [RB-1:0] c,
                                                input dmc_pkg::dir_t d);
        logic [CB-1:0] a;
        unique case (d)
            dmc_pkg::DIR_UP:    a = {r - RB'(1), c};
            dmc_pkg::DIR_LEFT:  a = {r, c - RB'(1)};
            dmc_pkg::DIR_RIGHT: a = {r, c + RB'(1)};
            dmc_pkg::DIR_DOWN:  a = {r + RB'(1), c};
            default:            a = {r, c};
        endcase
        return a;
    endfunction

    // Row or column coordinate reduced to its low five bits.
    function automatic logic [dmc_pkg::FIELD_W-1:0] fld(input logic [RB-1:0] v);
        logic [XW-1:0] t;
        t = XW'(v);
        return t[dmc_pkg::FIELD_W-1:0];
    endfunction

    // Visited map: one bit per cell, cleared by a sweep at each start.
    dmc_ram #(
        .WIDTH (1),
        .DEPTH (MEM_DEPTH)
    ) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .addr  (vis_addr),
        .wdata (vis_wdata),
        .rdata (vis_rdata)
    );

    // Path stack: the cells from the entrance to the current cell.
    dmc_ram #(
        .WIDTH (CB),
        .DEPTH (MEM_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .addr  (stk_addr),
        .wdata (stk_wdata),
        .rdata (stk_rdata)
    );

    // Start row: random word modulo the grid height.
    dmc_rem #(
        .DIVW (DW)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (random_word),
        .divisor   (h_eff),
        .done      (rem_done),
        .remainder (rem_value)
    );

    // Control state and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dmc_pkg::S_IDLE;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            count_reg   <= '0;
            nbr_reg     <= dmc_pkg::DIR_UP;
            clr_reg     <= '0;
            result_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            count_reg   <= count_next;
            nbr_reg     <= nbr_next;
            clr_reg     <= clr_next;
            result_reg  <= result_next;
        end
    end

    // Request payload and neighbor scratch bits.
    always_ff @(posedge clk)
    begin
        rnd_reg  <= rnd_next;
        mod3_reg <= mod3_next;
        seen_reg <= seen_next;
    end

    // Random word modulo three by reciprocal multiplication.
    always_comb
    begin
        recip_prod = 33'(random_word) * 33'(dmc_pkg::RECIP3);
        recip_q    = recip_prod[dmc_pkg::RECIP3_SHIFT +: 16];
        mod3_diff  = 18'(random_word) - (18'(recip_q) << 1) - 18'(recip_q);
    end

    // Neighbor availability and choice of the next cell.
    always_comb
    begin
        h_eff      = clamp_dim(cfg.height);
        w_eff      = clamp_dim(cfg.width);
        inbound[0] = (cur_row_reg != '0);
        inbound[1] = (cur_col_reg != '0);
        inbound[2] = ((DW+1)'(cur_col_reg) + (DW+1)'(1)) < (DW+1)'(w_eff);
        inbound[3] = ((DW+1)'(cur_row_reg) + (DW+1)'(1)) < (DW+1)'(h_eff);
        visited    = {vis_rdata, seen_reg};
        free_nbr   = inbound & ~visited;
        found      = 3'(free_nbr[0]) + 3'(free_nbr[1]) + 3'(free_nbr[2])
                   + 3'(free_nbr[3]);
        case (found)
            3'd2:    pick = {1'b0, rnd_reg[0]};
            3'd3:    pick = mod3_reg;
            3'd4:    pick = rnd_reg[1:0];
            default: pick = 2'd0;
        endcase
        // Take the free neighbor whose rank among the free ones is pick.
        chosen   = dmc_pkg::DIR_UP;
        seen_cnt = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (free_nbr[i])
            begin
                if (seen_cnt == {1'b0, pick})
                begin
                    chosen = dmc_pkg::dir_t'(2'(i));
                end
                seen_cnt = seen_cnt + 3'd1;
            end
        end
        chosen_cell = step_cell(cur_row_reg, cur_col_reg, chosen);
        push_ok     = (found != 3'd0) && (count_reg < SCW'(CELLS));
    end

    // Search state machine with memory requests and result formation.
    always_comb
    begin
        state_next   = state_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        count_next   = count_reg;
        rnd_next     = rnd_reg;
        mod3_next    = mod3_reg;
        nbr_next     = nbr_reg;
        seen_next    = seen_reg;
        clr_next     = clr_reg;
        result_next  = result_reg;
        result_next.strobe = 1'b0;
        vis_we       = 1'b0;
        vis_addr     = step_cell(cur_row_reg, cur_col_reg, nbr_reg);
        vis_wdata    = 1'b0;
        stk_we       = 1'b0;
        stk_addr     = CB'(count_reg);
        stk_wdata    = chosen_cell;
        rem_start    = 1'b0;

        unique case (state_reg)
            dmc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    rnd_next  = random_word;
                    mod3_next = mod3_diff[1:0];
                    if (dmc_pkg::opcode_t'(opcode) == dmc_pkg::OP_START)
                    begin
                        rem_start  = 1'b1;
                        clr_next   = '0;
                        state_next = dmc_pkg::S_CLEAR;
                    end
                    else if (count_reg == '0)
                    begin
                        // Empty stack: report done at the current cell.
                        result_next.strobe      = 1'b1;
                        result_next.kind        = dmc_pkg::EV_DONE;
                        result_next.from_row    = fld(cur_row_reg);
                        result_next.from_col    = fld(cur_col_reg);
                        result_next.to_row      = fld(cur_row_reg);
                        result_next.to_col      = fld(cur_col_reg);
                        result_next.dir         = dmc_pkg::DIR_UP;
                        result_next.exit_opened = 1'b0;
                    end
                    else
                    begin
                        nbr_next   = dmc_pkg::DIR_UP;
                        state_next = dmc_pkg::S_READ;
                    end
                end
            end

            dmc_pkg::S_CLEAR:
            begin
                // Sweep the visited map while the start row is computed.
                vis_we    = 1'b1;
                vis_addr  = clr_reg;
                vis_wdata = 1'b0;
                if (clr_reg != '1)
                begin
                    clr_next = clr_reg + CB'(1);
                end
                else if (rem_done)
                begin
                    state_next = dmc_pkg::S_ENTER;
                end
            end

            dmc_pkg::S_ENTER:
            begin
                // Entrance on the left column: mark, push, report.
                vis_we       = 1'b1;
                vis_addr     = {RB'(rem_value), RB'(0)};
                vis_wdata    = 1'b1;
                stk_we       = 1'b1;
                stk_addr     = '0;
                stk_wdata    = {RB'(rem_value), RB'(0)};
                count_next   = SCW'(1);
                cur_row_next = RB'(rem_value);
                cur_col_next = '0;
                result_next.strobe      = 1'b1;
                result_next.kind        = dmc_pkg::EV_ENTRANCE;
                result_next.from_row    = fld(RB'(rem_value));
                result_next.from_col    = fld(RB'(0));
                result_next.to_row      = fld(RB'(rem_value));
                result_next.to_col      = fld(RB'(0));
                result_next.dir         = dmc_pkg::DIR_LEFT;
                result_next.exit_opened = 1'b0;
                state_next   = dmc_pkg::S_IDLE;
            end

            dmc_pkg::S_READ:
            begin
                // One neighbor read per cycle; each read's data comes through the RAM's read register.
                if (nbr_reg != dmc_pkg::DIR_UP)
                begin
                    seen_next[2'(nbr_reg) - 2'd1] = vis_rdata;
                end
                if (nbr_reg == dmc_pkg::DIR_DOWN)
                begin
                    state_next = dmc_pkg::S_DECIDE;
                end
                else
                begin
                    nbr_next = dmc_pkg::dir_t'(2'(nbr_reg) + 2'd1);
                end
            end

            dmc_pkg::S_DECIDE:
            begin
                if (push_ok)
                begin
                    // Carve into the chosen neighbor.
                    vis_we       = 1'b1;
                    vis_addr     = chosen_cell;
                    vis_wdata    = 1'b1;
                    stk_we       = 1'b1;
                    stk_addr     = CB'(count_reg);
                    stk_wdata    = chosen_cell;
                    count_next   = count_reg + SCW'(1);
                    cur_row_next = chosen_cell[CB-1:RB];
                    cur_col_next = chosen_cell[RB-1:0];
                    result_next.strobe      = 1'b1;
                    result_next.kind        = dmc_pkg::EV_CARVE;
                    result_next.from_row    = fld(cur_row_reg);
                    result_next.from_col    = fld(cur_col_reg);
                    result_next.to_row      = fld(chosen_cell[CB-1:RB]);
                    result_next.to_col      = fld(chosen_cell[RB-1:0]);
                    result_next.dir         = chosen;
                    result_next.exit_opened =
                        ((chosen == dmc_pkg::DIR_LEFT) || (chosen == dmc_pkg::DIR_RIGHT))
                        && (DW'(chosen_cell[RB-1:0]) == (w_eff - DW'(1)));
                    state_next   = dmc_pkg::S_IDLE;
                end
                else
                begin
                    count_next = count_reg - SCW'(1);
                    if (count_reg == SCW'(1))
                    begin
                        // Last cell popped: the maze is done.
                        result_next.strobe      = 1'b1;
                        result_next.kind        = dmc_pkg::EV_DONE;
                        result_next.from_row    = fld(cur_row_reg);
                        result_next.from_col    = fld(cur_col_reg);
                        result_next.to_row      = fld(cur_row_reg);
                        result_next.to_col      = fld(cur_col_reg);
                        result_next.dir         = dmc_pkg::DIR_UP;
                        result_next.exit_opened = 1'b0;
                        state_next = dmc_pkg::S_IDLE;
                    end
                    else
                    begin
                        // Fetch the entry under the top.
                        stk_addr   = CB'(count_reg - SCW'(2));
                        state_next = dmc_pkg::S_POP;
                    end
                end
            end

            dmc_pkg::S_POP:
            begin
                cur_row_next = stk_rdata[CB-1:RB];
                cur_col_next = stk_rdata[RB-1:0];
                result_next.strobe      = 1'b1;
                result_next.kind        = dmc_pkg::EV_BACKTRACK;
                result_next.from_row    = fld(cur_row_reg);
                result_next.from_col    = fld(cur_col_reg);
                result_next.to_row      = fld(stk_rdata[CB-1:RB]);
                result_next.to_col      = fld(stk_rdata[RB-1:0]);
                result_next.dir         = dmc_pkg::DIR_UP;
                result_next.exit_opened = 1'b0;
                state_next = dmc_pkg::S_IDLE;
            end

            default:
            begin
                state_next = dmc_pkg::S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != dmc_pkg::S_IDLE);
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== src/dfs_maze_carver.sv =====
// Top level of the depth-first maze carver: APB size registers and ports.
// Depends on dmc_pkg and dmc_seq (which holds the memories).
//
// Each request is taken when start is high and busy is low; every request
// gives exactly one result, shown for one cycle with result_strobe high,
// and the receiver cannot hold it off. A step request that carves reads
// the four neighbors from the single-port visited map, decides and then
// gives its result; one that backtracks also reads the path stack, and a
// step on an empty stack answers without any memory read. A start request
// sweeps the whole visited map, one entry per cycle. Size registers are to
// be written only while idle; the block itself does not enforce this.
`default_nettype none

module dfs_maze_carver #(
    parameter int MAX_DIM = dmc_pkg::MAX_DIM_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           opcode,
    input  wire logic [dmc_pkg::RND_W-1:0]      random_word,
    output logic                                result_strobe,
    output logic      [1:0]                     event_kind,
    output logic      [dmc_pkg::FIELD_W-1:0]    from_row,
    output logic      [dmc_pkg::FIELD_W-1:0]    from_col,
    output logic      [dmc_pkg::FIELD_W-1:0]    to_row,
    output logic      [dmc_pkg::FIELD_W-1:0]    to_col,
    output logic      [1:0]                     carve_dir,
    output logic                                exit_opened,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dmc_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [dmc_pkg::APB_W-1:0]      pwdata,
    output logic      [dmc_pkg::APB_W-1:0]      prdata,
    output logic                                pready
);

    logic [dmc_pkg::CFG_W-1:0] height_reg, height_next;
    logic [dmc_pkg::CFG_W-1:0] width_reg,  width_next;
    logic                      wr_en;
    dmc_pkg::cfg_t             cfg;
    dmc_pkg::result_t          result;

    // Size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= dmc_pkg::DIM_RESET;
            width_reg  <= dmc_pkg::DIM_RESET;
        end
        else
        begin
            height_reg <= height_next;
            width_reg  <= width_next;
        end
    end

    // APB write decode on the word address bit.
    always_comb
    begin
        wr_en       = psel && penable && pwrite && pready;
        height_next = height_reg;
        width_next  = width_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                dmc_pkg::REG_HEIGHT: height_next = pwdata[dmc_pkg::CFG_W-1:0];
                dmc_pkg::REG_WIDTH:  width_next  = pwdata[dmc_pkg::CFG_W-1:0];
                default:             height_next = height_reg;
            endcase
        end
    end

    // APB read mux.
    always_comb
    begin
        unique case (paddr[2])
            dmc_pkg::REG_HEIGHT: prdata = dmc_pkg::APB_W'(height_reg);
            dmc_pkg::REG_WIDTH:  prdata = dmc_pkg::APB_W'(width_reg);
            default:             prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign cfg.height = height_reg;
    assign cfg.width  = width_reg;

    // Search sequencer with the visited map and path stack.
    dmc_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .random_word (random_word),
        .cfg         (cfg),
        .busy        (busy),
        .result      (result)
    );

    // Result ports.
    assign result_strobe = result.strobe;
    assign event_kind    = result.kind;
    assign from_row      = result.from_row;
    assign from_col      = result.from_col;
    assign to_row        = result.to_row;
    assign to_col        = result.to_col;
    assign carve_dir     = result.dir;
    assign exit_opened   = result.exit_opened;

endmodule

`default_nettype wire

// ===== src/dmc_checker.sv =====
// Port-level checks of the maze carver, bound to the top level.
// Depends on dmc_pkg and dfs_maze_carver.
`default_nettype none

module dmc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       result_strobe,
    input wire logic [1:0] event_kind,
    input wire logic [4:0] from_row,
    input wire logic [4:0] from_col,
    input wire logic [4:0] to_row,
    input wire logic [4:0] to_col,
    input wire logic [1:0] carve_dir,
    input wire logic       exit_opened
);

    // A result only shows once the block has finished its request.
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> !busy)
        else $error("result shown while busy");

    // An accepted request either answers at once or keeps the block busy.
    a_accept_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || result_strobe))
        else $error("accepted request was dropped");

    // Busy only ends together with a result.
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_strobe)
        else $error("busy ended without a result");

    // The entrance is on the left column, opened through its left wall.
    a_entrance: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (event_kind == dmc_pkg::EV_ENTRANCE)) |->
        ((from_row == to_row) && (from_col == 5'd0) && (to_col == 5'd0)
         && (carve_dir == dmc_pkg::DIR_LEFT) && !exit_opened))
        else $error("malformed entrance result");

endmodule

bind dfs_maze_carver dmc_checker u_dmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .event_kind    (event_kind),
    .from_row      (from_row),
    .from_col      (from_col),
    .to_row        (to_row),
    .to_col        (to_col),
    .carve_dir     (carve_dir),
    .exit_opened   (exit_opened)
);

`default_nettype wire
